// ===== design/temp_scratchpad_crc_alarm_core_macros.svh =====
// Assertion helpers for the core design file.
`ifndef TEMP_SCRATCHPAD_CRC_ALARM_CORE_MACROS_SVH
`define TEMP_SCRATCHPAD_CRC_ALARM_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define TSCA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsca: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset
`define TSCA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsca: next-cycle check failed");

`endif

// ===== design/tsca_pkg.sv =====
package tsca_pkg;

    // Default geometry
    localparam int SCRATCH_BYTES_DEF = 9;
    localparam int NUM_SENSORS_DEF   = 3;

    // Field widths
    localparam int SENSOR_W = 2;
    localparam int BYTE_W   = 8;
    localparam int TEMP_W   = 16;
    localparam int LIMIT_W  = 12;
    localparam int DUTY_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    // Stream word layout
    localparam int S_TUSER_W = 3;   // sensor_id, frame_start
    localparam int M_TDATA_W = 40;  // 35 payload bits, zero padded to bytes
    localparam int M_TUSER_W = 2;   // result_sensor

    // Reflected Dallas/Maxim CRC-8 polynomial
    localparam logic [7:0] CRC_POLY_REFL = 8'b1000_1100;

    // Configuration reset values
    localparam logic signed [LIMIT_W-1:0] LOW_LIMIT_RST  = 12'sd80;
    localparam logic signed [LIMIT_W-1:0] HIGH_LIMIT_RST = 12'sd400;
    localparam logic [DUTY_W-1:0]         ALARM_DUTY_RST = 8'd200;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_LIMIT  = 2'd0,
        REG_HIGH_LIMIT = 2'd1,
        REG_ALARM_DUTY = 2'd2
    } cfg_reg_t;

    // One result word
    typedef struct packed {
        logic [SENSOR_W-1:0]      sensor;
        logic signed [TEMP_W-1:0] temperature;
        logic                     crc_ok;
        logic [7:0]               crc_value;
        logic                     out_of_range;
        logic [DUTY_W-1:0]        drive_duty;
        logic                     bus_reset_request;
    } result_t;

    // One byte of the reflected CRC-8, unrolled over eight bit steps
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
        logic [7:0] crc;
        logic [7:0] data;
        logic       fb;
        crc  = crc_in;
        data = data_in;
        for (int k = 0; k < 8; k++) begin
            fb   = crc[0] ^ data[0];
            crc  = crc >> 1;
            data = data >> 1;
            if (fb)
            begin
                crc = crc ^ CRC_POLY_REFL;
            end
        end
        return crc;
    endfunction

endpackage

// ===== design/temp_scratchpad_crc_alarm_core.sv =====
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   tdata: scratch_byte; tuser: sensor_id, frame_start
// m_*       out  m_tvalid/m_tready   tdata: result fields; tuser: result_sensor
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// One byte word is taken per cycle while s_tready is high; the CRC step, capture and
// alarm check all finish in the accepting cycle. The result word is registered into
// the result register, or into the skid register (a two-deep output holding a second
// result word while m_tready is low); s_tready drops only when both are full.
// rst_n clears the byte count, CRC, alarm flags, duty and limits to reset values.

`include "temp_scratchpad_crc_alarm_core_macros.svh"

module temp_scratchpad_crc_alarm_core #(
    parameter int SCRATCH_BYTES = tsca_pkg::SCRATCH_BYTES_DEF,
    parameter int NUM_SENSORS   = tsca_pkg::NUM_SENSORS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tsca_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] scratch_byte
    input  logic [tsca_pkg::S_TUSER_W-1:0]    s_tuser,   // [1:0] sensor_id, [2] frame_start
    // master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tsca_pkg::M_TDATA_W-1:0]    m_tdata,   // [15:0] temperature,
                                                         // [16] crc_ok,
                                                         // [24:17] crc_value,
                                                         // [25] out_of_range,
                                                         // [33:26] drive_duty,
                                                         // [34] bus_reset_request,
                                                         // [39:35] zero
    output logic [tsca_pkg::M_TUSER_W-1:0]    m_tuser,   // [1:0] result_sensor
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsca_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CNT_W = $clog2(SCRATCH_BYTES);
    localparam logic [CNT_W-1:0] LAST_BYTE = CNT_W'(SCRATCH_BYTES - 1);
    localparam logic [CNT_W-1:0] TEMP_HI_BYTE = CNT_W'(1);
    localparam logic [tsca_pkg::SENSOR_W:0] SENSOR_LIMIT =
        (tsca_pkg::SENSOR_W + 1)'(NUM_SENSORS);

    // Configuration registers
    logic signed [tsca_pkg::LIMIT_W-1:0] low_limit_reg;
    logic signed [tsca_pkg::LIMIT_W-1:0] high_limit_reg;
    logic [tsca_pkg::DUTY_W-1:0]         alarm_duty_reg;

    // Frame state
    logic [CNT_W-1:0]                byte_count_reg, byte_count_next;
    logic [7:0]                      crc_reg, crc_next;
    logic [tsca_pkg::BYTE_W-1:0]     temp_lo_reg, temp_hi_reg;
    logic [tsca_pkg::SENSOR_W-1:0]   sensor_reg, sensor_next;
    logic [NUM_SENSORS-1:0]          flags_reg, flags_next;
    logic [tsca_pkg::DUTY_W-1:0]     duty_reg, duty_next;

    // Output stage
    logic                            out_valid_reg, skid_valid_reg;
    tsca_pkg::result_t               out_reg, skid_reg, res_next;

    logic                            in_acc, out_pop, push;
    logic                            frame_start;
    logic [tsca_pkg::SENSOR_W-1:0]   sensor_id;
    logic [CNT_W-1:0]                eff_count;
    logic                            is_first, is_last;
    logic [7:0]                      crc_base;
    logic signed [tsca_pkg::TEMP_W-1:0] temp_val, low_ext, high_ext;
    logic                            crc_match, alarm, sensor_known, flag_out;

    assign cfg_ready   = 1'b1;
    assign s_tready    = !skid_valid_reg;
    assign in_acc      = s_tvalid && s_tready;
    assign out_pop     = m_tvalid && m_tready;
    assign sensor_id   = s_tuser[tsca_pkg::SENSOR_W-1:0];
    assign frame_start = s_tuser[tsca_pkg::SENSOR_W];

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_limit_reg  <= tsca_pkg::LOW_LIMIT_RST;
            high_limit_reg <= tsca_pkg::HIGH_LIMIT_RST;
            alarm_duty_reg <= tsca_pkg::ALARM_DUTY_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tsca_pkg::REG_LOW_LIMIT:  low_limit_reg  <= cfg_data;
                tsca_pkg::REG_HIGH_LIMIT: high_limit_reg <= cfg_data;
                tsca_pkg::REG_ALARM_DUTY: alarm_duty_reg <= cfg_data[tsca_pkg::DUTY_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Position in frame; count zero always opens a new frame
    assign eff_count = frame_start ? '0 : byte_count_reg;
    assign is_first  = (eff_count == '0);
    assign is_last   = (eff_count == LAST_BYTE);
    assign crc_base  = is_first ? 8'h00 : crc_reg;

    // Evaluate the CRC byte against stored frame state
    assign temp_val  = {temp_hi_reg, temp_lo_reg};
    assign low_ext   = {{(tsca_pkg::TEMP_W - tsca_pkg::LIMIT_W){low_limit_reg[tsca_pkg::LIMIT_W-1]}},
                        low_limit_reg};
    assign high_ext  = {{(tsca_pkg::TEMP_W - tsca_pkg::LIMIT_W){high_limit_reg[tsca_pkg::LIMIT_W-1]}},
                        high_limit_reg};
    assign crc_match = (crc_reg == s_tdata);
    assign alarm     = (temp_val < low_ext) || (temp_val > high_ext);
    assign sensor_known = ({1'b0, sensor_reg} < SENSOR_LIMIT);

    // Next frame state and alarm update
    always_comb
    begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        sensor_next     = is_first ? sensor_id : sensor_reg;
        flags_next      = flags_reg;
        duty_next       = duty_reg;
        flag_out        = 1'b0;
        if (is_last)
        begin
            byte_count_next = '0;
            crc_next        = 8'h00;
            if (sensor_known && crc_match)
            begin
                duty_next = alarm ? alarm_duty_reg : '0;
            end
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                if (sensor_reg == tsca_pkg::SENSOR_W'(i))
                begin
                    if (crc_match)
                    begin
                        flags_next[i] = alarm;
                    end
                    flag_out = flags_next[i];
                end
            end
        end
        else
        begin
            byte_count_next = eff_count + CNT_W'(1);
            crc_next        = tsca_pkg::crc8_byte(crc_base, s_tdata);
        end
    end

    // Assemble the result word
    always_comb
    begin
        res_next.sensor            = sensor_reg;
        res_next.temperature       = temp_val;
        res_next.crc_ok            = crc_match;
        res_next.crc_value         = crc_reg;
        res_next.out_of_range      = flag_out;
        res_next.drive_duty        = duty_next;
        res_next.bus_reset_request = !crc_match;
    end

    assign push = in_acc && is_last;

    // Advance frame state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            crc_reg        <= 8'h00;
            sensor_reg     <= '0;
            flags_reg      <= '0;
            duty_reg       <= '0;
            temp_lo_reg    <= '0;
            temp_hi_reg    <= '0;
        end
        else if (in_acc)
        begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            sensor_reg     <= sensor_next;
            flags_reg      <= flags_next;
            duty_reg       <= duty_next;
            if (is_first)
            begin
                temp_lo_reg <= s_tdata;
            end
            if (eff_count == TEMP_HI_BYTE)
            begin
                temp_hi_reg <= s_tdata;
            end
        end
    end

    // Output and skid occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Output and skid payload
    always_ff @(posedge clk)
    begin
        if (out_pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= res_next;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                out_reg <= res_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.sensor;
    assign m_tdata  = {5'b0,
                       out_reg.bus_reset_request,
                       out_reg.drive_duty,
                       out_reg.out_of_range,
                       out_reg.crc_value,
                       out_reg.crc_ok,
                       out_reg.temperature};

    // Skid holds data only behind a full result register
    `TSCA_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // Byte count never passes the CRC byte
    `TSCA_ASSERT_IMPL(a_count_range, 1'b1, byte_count_reg <= LAST_BYTE)
    // A shown result is either a match or a bus reset request, never both
    `TSCA_ASSERT_IMPL(a_ok_vs_reset, m_tvalid, m_tdata[16] != m_tdata[34])
    // Closing a frame returns the count to zero
    `TSCA_ASSERT_NEXT(a_frame_closes, push, byte_count_reg == '0)

endmodule

// ===== tb/sv/temp_scratchpad_crc_alarm_core_tb.sv =====
module temp_scratchpad_crc_alarm_core_tb;

    localparam int SCR_BYTES      = tsca_pkg::SCRATCH_BYTES_DEF;
    localparam int NUM_SENS       = tsca_pkg::NUM_SENSORS_DEF;
    localparam int DIR_ROWS       = 28;
    localparam int PHASES         = 5;
    localparam int ITEMS_PER_PHASE = 280;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;

    // Index with no register behind it: a write must change nothing
    localparam logic [tsca_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam tsca_pkg::result_t NO_REPORT = '0;
    // All-zero frame right after reset: CRC 0 matches, 0 is below 5 C
    localparam tsca_pkg::result_t ZERO_FRAME_REPORT = '{2'd0, 16'sd0, 1'b1, 8'h00, 1'b1,
                                                        tsca_pkg::ALARM_DUTY_RST, 1'b0};

    typedef struct packed {
        logic [tsca_pkg::SENSOR_W-1:0] sid;
        logic [tsca_pkg::BYTE_W-1:0]   data;
        logic                          st;
        logic                          fix_crc;   // send the running CRC instead of data
        logic                          typed;     // use want instead of the tracker's report
        tsca_pkg::result_t             want;
    } stim_row_t;

    // Directed frames
    stim_row_t dir_rows [DIR_ROWS] = '{
        // zeros from sensor 0, fixed report
        '{2'd0, 8'h00, 1'b1, 1'b0, 1'b0, NO_REPORT},
        '{2'd0, 8'h00, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd0, 8'h00, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd0, 8'h00, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd0, 8'h00, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd0, 8'h00, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd0, 8'h00, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd0, 8'h00, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd0, 8'h00, 1'b0, 1'b0, 1'b1, ZERO_FRAME_REPORT},
        // partial frame, dropped by the restart below
        '{2'd1, 8'hFF, 1'b1, 1'b0, 1'b0, NO_REPORT},
        // sensor 3 does not exist; tags change mid-frame; 0x8000 temperature
        '{2'd3, 8'h00, 1'b1, 1'b0, 1'b0, NO_REPORT},
        '{2'd0, 8'h80, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd2, 8'hAA, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd1, 8'h55, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd3, 8'hFF, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd0, 8'h01, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd2, 8'h80, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd1, 8'h7F, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd3, 8'h00, 1'b0, 1'b0, 1'b0, NO_REPORT},
        // sensor 2 without frame_start, 0x7FFF temperature, good CRC
        '{2'd2, 8'hFF, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd1, 8'h7F, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd0, 8'hFF, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd3, 8'h00, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd2, 8'h5A, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd2, 8'hA5, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd2, 8'h10, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd2, 8'hEF, 1'b0, 1'b0, 1'b0, NO_REPORT},
        '{2'd2, 8'h00, 1'b0, 1'b1, 1'b0, NO_REPORT}
    };

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [tsca_pkg::BYTE_W-1:0]         s_tdata = '0;
    logic [tsca_pkg::S_TUSER_W-1:0]      s_tuser = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [tsca_pkg::M_TDATA_W-1:0]      m_tdata;
    logic [tsca_pkg::M_TUSER_W-1:0]      m_tuser;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [tsca_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [tsca_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    // Tracker state: scratchpad assembly, alarm flags, shared duty, registers
    int                                  scratch_pos;
    logic [7:0]                          crc_run;
    logic [7:0]                          temp_lo;
    logic [7:0]                          temp_hi;
    logic [tsca_pkg::SENSOR_W-1:0]       frame_sensor;
    logic                                alarm_flag [NUM_SENS];
    logic [tsca_pkg::DUTY_W-1:0]         drive_now;
    logic signed [tsca_pkg::LIMIT_W-1:0] lim_lo;
    logic signed [tsca_pkg::LIMIT_W-1:0] lim_hi;
    logic [tsca_pkg::DUTY_W-1:0]         duty_set;

    tsca_pkg::result_t                   expected_reports [$];
    int                                  error_count = 0;
    int                                  items_sent = 0;
    int                                  idle_cycles = 0;
    int                                  rx_wait = 0;
    logic                                tx_calm = 1'b0;
    logic                                rx_calm = 1'b0;

    temp_scratchpad_crc_alarm_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Reflected CRC-8, data taken LSB first
    function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] d);
        logic [7:0] r;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ d[i])
                r = (r >> 1) ^ tsca_pkg::CRC_POLY_REFL;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    // Advance the tracker by one byte; report when the CRC byte closes a frame
    task automatic track_scratch_byte(input logic [tsca_pkg::SENSOR_W-1:0] sid,
                                      input logic [7:0] b,
                                      input logic st, output logic done,
                                      output tsca_pkg::result_t rep);
        logic signed [tsca_pkg::TEMP_W-1:0] t;
        logic                               hit;
        done = 1'b0;
        rep  = '0;
        if (st)
            scratch_pos = 0;
        if (scratch_pos == 0)
        begin
            crc_run      = '0;
            frame_sensor = sid;
        end
        if (scratch_pos < SCR_BYTES - 1)
        begin
            if (scratch_pos == 0)
                temp_lo = b;
            else if (scratch_pos == 1)
                temp_hi = b;
            crc_run = crc_next(crc_run, b);
            scratch_pos++;
        end
        else
        begin
            t = {temp_hi, temp_lo};
            // Alarm and duty move only on a CRC match from a real sensor
            if (frame_sensor < NUM_SENS)
            begin
                if (crc_run == b)
                begin
                    hit = (t < lim_lo) || (t > lim_hi);
                    alarm_flag[frame_sensor] = hit;
                    drive_now = hit ? duty_set : '0;
                end
                rep.out_of_range = alarm_flag[frame_sensor];
            end
            rep.sensor            = frame_sensor;
            rep.temperature       = t;
            rep.crc_ok            = (crc_run == b);
            rep.crc_value         = crc_run;
            rep.drive_duty        = drive_now;
            rep.bus_reset_request = (crc_run != b);
            done        = 1'b1;
            scratch_pos = 0;
            crc_run     = '0;
        end
    endtask

    // Offer one byte word, wait for the handshake, record what it should cause
    task automatic offer_word(input logic [tsca_pkg::SENSOR_W-1:0] sid, input logic [7:0] b,
                              input logic st, input logic typed,
                              input tsca_pkg::result_t typed_rep);
        int                gap;
        logic              done;
        tsca_pkg::result_t rep;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {st, sid};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_scratch_byte(sid, b, st, done, rep);
        if (done)
            expected_reports.push_back(typed ? typed_rep : rep);
        items_sent++;
    endtask

    // One random frame; some are cut short, retagged mid-frame or carry a bad CRC
    task automatic send_frame();
        int                            kind;
        int                            len;
        logic [tsca_pkg::SENSOR_W-1:0] sid;
        logic [15:0]                   temp;
        logic                          st;
        logic                          noisy_tag;
        logic                          good_crc;
        logic [7:0]                    b;
        kind = $urandom_range(0, 99);
        sid  = ($urandom_range(0, 7) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 3))
            0: temp = 16'(int'(lim_lo) + int'($urandom_range(0, 4)) - 2);
            1: temp = 16'(int'(lim_hi) + int'($urandom_range(0, 4)) - 2);
            2: temp = 16'(int'($urandom_range(0, 3100)) - 1000);
            default: temp = 16'($urandom);
        endcase
        len       = (kind < 8) ? $urandom_range(1, SCR_BYTES - 1) : SCR_BYTES;
        noisy_tag = (kind >= 8 && kind < 20);
        good_crc  = ($urandom_range(0, 6) != 0);
        // implicit start only on a clean boundary, except for the frames of kinds 20 to 24
        if (kind >= 20 && kind < 25)
            st = 1'b0;
        else
            st = (scratch_pos != 0) || ($urandom_range(0, 3) != 0);
        for (int k = 0; k < len; k++)
        begin
            if (k == 0)
                b = temp[7:0];
            else if (k == 1)
                b = temp[15:8];
            else if (k == SCR_BYTES - 1 && good_crc)
                b = crc_run;
            else
                b = 8'($urandom);
            offer_word((k == 0 || !noisy_tag) ? sid : 2'($urandom), b,
                       (k == 0) ? st : 1'b0, 1'b0, NO_REPORT);
        end
    endtask

    task automatic write_reg(input logic [tsca_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tsca_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            tsca_pkg::REG_LOW_LIMIT:  lim_lo   = val;
            tsca_pkg::REG_HIGH_LIMIT: lim_hi   = val;
            tsca_pkg::REG_ALARM_DUTY: duty_set = val[tsca_pkg::DUTY_W-1:0];
            default: ;
        endcase
    endtask

    // Hold the stream until every expected report is back, then let the core settle
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_report(input tsca_pkg::result_t got);
        tsca_pkg::result_t want;
        if (expected_reports.size() == 0)
        begin
            $error("report word with nothing expected: %p", got);
            error_count++;
            return;
        end
        want = expected_reports.pop_front();
        check_field("result_sensor", 16'(want.sensor), 16'(got.sensor));
        check_field("temperature", want.temperature, got.temperature);
        check_field("crc_ok", 16'(want.crc_ok), 16'(got.crc_ok));
        check_field("crc_value", 16'(want.crc_value), 16'(got.crc_value));
        check_field("out_of_range", 16'(want.out_of_range), 16'(got.out_of_range));
        check_field("drive_duty", 16'(want.drive_duty), 16'(got.drive_duty));
        check_field("bus_reset_request", 16'(want.bus_reset_request),
                    16'(got.bus_reset_request));
    endtask

    // Report sink: check each word, then stall m_tready for a random count
    always @(posedge clk or negedge rst_n)
    begin : report_sink
        int stall;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            check_report('{m_tuser, m_tdata[15:0], m_tdata[16], m_tdata[24:17],
                           m_tdata[25], m_tdata[33:26], m_tdata[34]});
            stall = rx_calm ? 0 : $urandom_range(0, 3);
            rx_wait  <= stall;
            m_tready <= (stall == 0);
        end
        else if (!m_tready)
        begin
            if (rx_wait <= 1)
                m_tready <= 1'b1;
            rx_wait <= rx_wait - 1;
        end
    end

    // Watchdog: end the run when no word moves on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[temp_scratchpad_crc_alarm_core] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int        frames;
        logic [11:0] pick;
        scratch_pos  = 0;
        crc_run      = '0;
        temp_lo      = '0;
        temp_hi      = '0;
        frame_sensor = '0;
        drive_now    = '0;
        lim_lo       = tsca_pkg::LOW_LIMIT_RST;
        lim_hi       = tsca_pkg::HIGH_LIMIT_RST;
        duty_set     = tsca_pkg::ALARM_DUTY_RST;
        foreach (alarm_flag[i])
            alarm_flag[i] = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames under reset register values
        foreach (dir_rows[i])
            offer_word(dir_rows[i].sid, dir_rows[i].fix_crc ? crc_run : dir_rows[i].data,
                       dir_rows[i].st, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                drain_reports();
                case (ph)
                    1:
                    begin
                        // widest window, full duty, junk above the duty bits
                        write_reg(tsca_pkg::REG_LOW_LIMIT, 12'(-880));
                        write_reg(tsca_pkg::REG_HIGH_LIMIT, 12'd2000);
                        write_reg(tsca_pkg::REG_ALARM_DUTY, {4'($urandom), 8'd255});
                        write_reg(REG_SPARE, 12'($urandom));
                    end
                    2:
                    begin
                        // crossed limits, zero duty
                        write_reg(tsca_pkg::REG_LOW_LIMIT, 12'd2000);
                        write_reg(tsca_pkg::REG_HIGH_LIMIT, 12'(-880));
                        write_reg(tsca_pkg::REG_ALARM_DUTY, {4'($urandom), 8'd0});
                    end
                    3:
                    begin
                        // single-point window: one temperature only is in range
                        pick = 12'(int'($urandom_range(0, 2880)) - 880);
                        write_reg(tsca_pkg::REG_LOW_LIMIT, pick);
                        write_reg(tsca_pkg::REG_HIGH_LIMIT, pick);
                        write_reg(tsca_pkg::REG_ALARM_DUTY, 12'($urandom));
                    end
                    default:
                    begin
                        write_reg(tsca_pkg::REG_HIGH_LIMIT,
                                  12'(int'($urandom_range(0, 2880)) - 880));
                        write_reg(tsca_pkg::REG_LOW_LIMIT,
                                  12'(int'($urandom_range(0, 2880)) - 880));
                        write_reg(tsca_pkg::REG_ALARM_DUTY, 12'($urandom));
                        write_reg(REG_SPARE, 12'($urandom));
                    end
                endcase
                cfg_valid <= 1'b0;
            end

            frames = 0;
            while (items_sent < DIR_ROWS + (ph + 1) * ITEMS_PER_PHASE)
            begin
                // redraw idle behavior in stretches, some with no idling at all
                if (frames % 16 == 0)
                begin
                    tx_calm = ($urandom_range(0, 3) == 0);
                    rx_calm = ($urandom_range(0, 3) == 0);
                end
                if (ph == 2 && frames == 10)
                    drain_reports();
                send_frame();
                frames++;
            end
        end

        drain_reports();
        if (error_count == 0)
            $display("[temp_scratchpad_crc_alarm_core] OK");
        else
            $display("[temp_scratchpad_crc_alarm_core] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/tsca_pkg.sv
design/temp_scratchpad_crc_alarm_core.sv
tb/sv/temp_scratchpad_crc_alarm_core_tb.sv
